FILE: design/udp_frame_clone_classifier_top_defines.svh
// Assertion macros for the UDP frame clone classifier.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef UDP_FRAME_CLONE_CLASSIFIER_TOP_DEFINES_SVH
`define UDP_FRAME_CLONE_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define UFCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define UFCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ufcc_pkg.sv
// Shared types and constants for the UDP frame clone classifier.
// No dependencies; imported by every module of the block.
package ufcc_pkg;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_BACK  = 2'd1,
    VERDICT_CLONE = 2'd2
  } verdict_t;

  // Configuration register indexes
  localparam logic CFG_MATCH_PORT  = 1'b0;
  localparam logic CFG_CLONE_COUNT = 1'b1;

  localparam logic [15:0] MATCH_PORT_RESET  = 16'd8901;
  localparam logic [26:0] CLONE_COUNT_RESET = 27'd4;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Fields captured over one frame, handed over on its last byte
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ethertype;
    logic [7:0]  protocol;
    logic [31:0] dest_addr;
    logic [19:0] partial_sum;
    logic [15:0] udp_port;
    logic        meta_flag;
    logic [31:0] meta_value;
    logic        len_ok;
  } frame_rec_t;

  // Decision for one frame, before the checksum fold
  typedef struct packed {
    verdict_t    verdict;
    logic [26:0] copies;
    logic        macs_swapped;
    logic        header_rewritten;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] dest_addr;
    logic [19:0] partial_sum;
  } class_rec_t;

endpackage

FILE: design/ufcc_parser.sv
// Byte parser: captures header fields and the running header sum per byte.
// Depends on ufcc_pkg; hands a frame record to the classify stage.
module ufcc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               meta_present,
  input  logic signed [31:0] meta_count,
  output logic               rec_valid,
  output ufcc_pkg::frame_rec_t rec,
  input  logic               rec_ready
);
  import ufcc_pkg::*;

  logic [15:0] byte_position;
  logic [47:0] dest_mac_reg;
  logic [47:0] src_mac_reg;
  logic [15:0] ethertype_reg;
  logic [3:0]  header_words;
  logic [7:0]  protocol_reg;
  logic [31:0] dest_addr_reg;
  logic [19:0] partial_sum;
  logic [7:0]  high_byte_hold;
  logic [15:0] udp_port_reg;
  logic        meta_flag_reg;
  logic [31:0] meta_value_reg;

  logic [15:0] byte_position_next;
  logic [47:0] dest_mac_next;
  logic [47:0] src_mac_next;
  logic [15:0] ethertype_next;
  logic [3:0]  header_words_next;
  logic [7:0]  protocol_next;
  logic [31:0] dest_addr_next;
  logic [19:0] partial_sum_next;
  logic [7:0]  high_byte_hold_next;
  logic [15:0] udp_port_next;
  logic        meta_flag_next;
  logic [31:0] meta_value_next;

  logic        first;
  logic        accept;
  logic [15:0] p;
  logic [6:0]  udp_start;
  logic [6:0]  udp_port_hi_pos;
  logic [6:0]  udp_port_lo_pos;
  logic [6:0]  udp_end_pos;

  assign p        = byte_position;
  assign first    = (byte_position == 16'd0);
  assign in_ready = !rec_valid || rec_ready;
  assign accept   = in_valid && in_ready;

  // Field capture: start from cleared fields and fresh metadata on the first byte of a frame
  always_comb begin
    dest_mac_next       = first ? 48'd0 : dest_mac_reg;
    src_mac_next        = first ? 48'd0 : src_mac_reg;
    ethertype_next      = first ? 16'd0 : ethertype_reg;
    header_words_next   = first ? 4'd0  : header_words;
    protocol_next       = first ? 8'd0  : protocol_reg;
    dest_addr_next      = first ? 32'd0 : dest_addr_reg;
    partial_sum_next    = first ? 20'd0 : partial_sum;
    high_byte_hold_next = first ? 8'd0  : high_byte_hold;
    udp_port_next       = first ? 16'd0 : udp_port_reg;
    meta_flag_next      = first ? meta_present : meta_flag_reg;
    meta_value_next     = first ? meta_count   : meta_value_reg;

    if (p < 16'd6) begin
      dest_mac_next = {dest_mac_next[39:0], data_byte};
    end else if (p < 16'd12) begin
      src_mac_next = {src_mac_next[39:0], data_byte};
    end else if (p < 16'd14) begin
      ethertype_next = {ethertype_next[7:0], data_byte};
    end

    if (p == 16'd14) begin
      header_words_next = data_byte[3:0];
    end
    if (p == 16'd23) begin
      protocol_next = data_byte;
    end
    if (p >= 16'd30 && p < 16'd34) begin
      dest_addr_next = {dest_addr_next[23:0], data_byte};
    end

    // Header word sum, skipping the checksum word
    if (p >= 16'd14 && p < 16'd30 && p != 16'd24 && p != 16'd25) begin
      if (!p[0]) begin
        high_byte_hold_next = data_byte;
      end else begin
        partial_sum_next = partial_sum_next + {4'd0, high_byte_hold_next, data_byte};
      end
    end

    // UDP destination port follows the IP header
    udp_start       = 7'd14 + {1'b0, header_words_next, 2'b00};
    udp_port_hi_pos = udp_start + 7'd2;
    udp_port_lo_pos = udp_start + 7'd3;
    udp_end_pos     = udp_start + 7'd7;
    if (p == {9'd0, udp_port_hi_pos}) begin
      udp_port_next = {data_byte, 8'd0};
    end else if (p == {9'd0, udp_port_lo_pos}) begin
      udp_port_next = {udp_port_next[15:8], data_byte};
    end

    // Advance position, saturating, and restart after the last byte
    if (last_byte) begin
      byte_position_next = 16'd0;
    end else if (p != 16'hFFFF) begin
      byte_position_next = p + 16'd1;
    end else begin
      byte_position_next = p;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dest_mac_reg   <= dest_mac_next;
      src_mac_reg    <= src_mac_next;
      ethertype_reg  <= ethertype_next;
      header_words   <= header_words_next;
      protocol_reg   <= protocol_next;
      dest_addr_reg  <= dest_addr_next;
      partial_sum    <= partial_sum_next;
      high_byte_hold <= high_byte_hold_next;
      udp_port_reg   <= udp_port_next;
      meta_flag_reg  <= meta_flag_next;
      meta_value_reg <= meta_value_next;
    end
  end

  // Frame record: load on the last byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (accept && last_byte) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      rec.dst_mac     <= dest_mac_next;
      rec.src_mac     <= src_mac_next;
      rec.ethertype   <= ethertype_next;
      rec.protocol    <= protocol_next;
      rec.dest_addr   <= dest_addr_next;
      rec.partial_sum <= partial_sum_next;
      rec.udp_port    <= udp_port_next;
      rec.meta_flag   <= meta_flag_next;
      rec.meta_value  <= meta_value_next;
      rec.len_ok      <= (p >= 16'd33) && (p >= {9'd0, udp_end_pos});
    end
  end

endmodule

FILE: design/ufcc_classify.sv
// Classify stage: matches the frame and picks verdict and rewrites.
// Depends on ufcc_pkg; takes a frame record, gives a decision record.
module ufcc_classify (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          match_port,
  input  logic [26:0]          clone_count,
  input  logic                 rec_valid,
  input  ufcc_pkg::frame_rec_t rec,
  output logic                 rec_ready,
  output logic                 cls_valid,
  output ufcc_pkg::class_rec_t cls,
  input  logic                 cls_ready
);
  import ufcc_pkg::*;

  class_rec_t cls_next;
  logic       matched;

  assign rec_ready = !cls_valid || cls_ready;

  // Decide the verdict for a handled frame
  always_comb begin
    matched = rec.len_ok && (rec.ethertype == ETH_IPV4) &&
              (rec.protocol == PROTO_UDP) && (rec.udp_port == match_port);

    cls_next.verdict          = VERDICT_PASS;
    cls_next.copies           = 27'd0;
    cls_next.macs_swapped     = 1'b0;
    cls_next.header_rewritten = 1'b0;
    cls_next.dst_mac          = rec.dst_mac;
    cls_next.src_mac          = rec.src_mac;
    cls_next.dest_addr        = rec.dest_addr;
    cls_next.partial_sum      = rec.partial_sum;

    if (matched) begin
      if (!rec.meta_flag) begin
        cls_next.verdict = VERDICT_CLONE;
        cls_next.copies  = clone_count;
      end else if (rec.meta_value == 32'd0) begin
        cls_next.dst_mac      = rec.src_mac;
        cls_next.src_mac      = rec.dst_mac;
        cls_next.macs_swapped = 1'b1;
      end else if (!rec.meta_value[31]) begin
        cls_next.dest_addr        = rec.dest_addr + rec.meta_value;
        cls_next.header_rewritten = 1'b1;
        cls_next.verdict          = VERDICT_BACK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (rec_ready) begin
      cls_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) begin
      cls <= cls_next;
    end
  end

endmodule

FILE: design/ufcc_csum.sv
// Checksum stage: folds the new address into the header sum, holds results.
// Depends on ufcc_pkg; drives the result ports of the top level.
module ufcc_csum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cls_valid,
  input  ufcc_pkg::class_rec_t cls,
  output logic                 cls_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           verdict,
  output logic [26:0]          copies,
  output logic                 macs_swapped,
  output logic                 header_rewritten,
  output logic [47:0]          new_dst_mac,
  output logic [47:0]          new_src_mac,
  output logic [31:0]          new_dest_addr,
  output logic [15:0]          new_ip_checksum
);
  import ufcc_pkg::*;

  logic [20:0] sum_raw;
  logic [16:0] sum_fold1;
  logic [15:0] sum_fold2;
  logic [15:0] csum_next;

  assign cls_ready = !out_valid || out_ready;

  // Ones-complement fold; two passes clear every carry
  always_comb begin
    sum_raw   = {1'b0, cls.partial_sum} + {5'd0, cls.dest_addr[31:16]} +
                {5'd0, cls.dest_addr[15:0]};
    sum_fold1 = {1'b0, sum_raw[15:0]} + {12'd0, sum_raw[20:16]};
    sum_fold2 = sum_fold1[15:0] + {15'd0, sum_fold1[16]};
    csum_next = cls.header_rewritten ? ~sum_fold2 : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cls_ready) begin
      out_valid <= cls_valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cls_ready && cls_valid) begin
      verdict          <= cls.verdict;
      copies           <= cls.copies;
      macs_swapped     <= cls.macs_swapped;
      header_rewritten <= cls.header_rewritten;
      new_dst_mac      <= cls.dst_mac;
      new_src_mac      <= cls.src_mac;
      new_dest_addr    <= cls.dest_addr;
      new_ip_checksum  <= csum_next;
    end
  end

endmodule

FILE: design/udp_frame_clone_classifier_top.sv
// Throughput: one frame byte per cycle while results drain; a stalled result output
// backs up into the input. A frame's result passes the parser record, classify and
// checksum registers in series after the edge that transfers its last byte.
// Reset clears the byte position and all stage valid flags; match_port returns
// to 8901 and clone_count to 4. Depends on ufcc_pkg and the parser, classify and
// checksum stages; assertion macros come from the defines header.
module udp_frame_clone_classifier_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [26:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               meta_present,
  input  logic signed [31:0] meta_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         verdict,
  output logic [26:0]        copies,
  output logic               macs_swapped,
  output logic               header_rewritten,
  output logic [47:0]        new_dst_mac,
  output logic [47:0]        new_src_mac,
  output logic [31:0]        new_dest_addr,
  output logic [15:0]        new_ip_checksum
);
  import ufcc_pkg::*;

  `include "udp_frame_clone_classifier_top_defines.svh"

  logic [15:0] match_port;
  logic [26:0] clone_count;
  logic        rec_valid;
  logic        rec_ready;
  frame_rec_t  rec;
  logic        cls_valid;
  logic        cls_ready;
  class_rec_t  cls;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_port  <= MATCH_PORT_RESET;
      clone_count <= CLONE_COUNT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MATCH_PORT:  match_port  <= cfg_data[15:0];
        CFG_CLONE_COUNT: clone_count <= cfg_data;
        default: ;
      endcase
    end
  end

  ufcc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .meta_present (meta_present),
    .meta_count   (meta_count),
    .rec_valid    (rec_valid),
    .rec          (rec),
    .rec_ready    (rec_ready)
  );

  ufcc_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .match_port  (match_port),
    .clone_count (clone_count),
    .rec_valid   (rec_valid),
    .rec         (rec),
    .rec_ready   (rec_ready),
    .cls_valid   (cls_valid),
    .cls         (cls),
    .cls_ready   (cls_ready)
  );

  ufcc_csum u_csum (
    .clk              (clk),
    .rst              (rst),
    .cls_valid        (cls_valid),
    .cls              (cls),
    .cls_ready        (cls_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .verdict          (verdict),
    .copies           (copies),
    .macs_swapped     (macs_swapped),
    .header_rewritten (header_rewritten),
    .new_dst_mac      (new_dst_mac),
    .new_src_mac      (new_src_mac),
    .new_dest_addr    (new_dest_addr),
    .new_ip_checksum  (new_ip_checksum)
  );

  // Checks
  `UFCC_ASSERT_NEXT(a_last_makes_record, in_valid && in_ready && last_byte, rec_valid, "last byte transfer did not produce a frame record")
  `UFCC_ASSERT_NOW(a_clone_no_rewrite, out_valid && (verdict == VERDICT_CLONE), !macs_swapped && !header_rewritten, "clone verdict with rewritten fields")
  `UFCC_ASSERT_NOW(a_csum_only_on_rewrite, out_valid && !header_rewritten, new_ip_checksum == 16'd0, "checksum set without header rewrite")
  `UFCC_ASSERT_NOW(a_copies_only_on_clone, out_valid && (copies != 27'd0), verdict == VERDICT_CLONE, "copies set outside clone verdict")

endmodule

FILE: verif/tb.sv
// Self-checking bench for udp_frame_clone_classifier_top: frames of bytes in, one verdict out.
// Needs ufcc_pkg and the block's RTL; a byte-level predictor in a scoreboard class
// works out each verdict, and random handshake gaps and stalls exercise flow control.
module tb;
  import ufcc_pkg::*;

  typedef struct {
    verdict_t    verdict;
    logic [26:0] copies;
    logic        swapped;
    logic        rewritten;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] dest_addr;
    logic [15:0] ip_csum;
  } frame_verdict_t;

  typedef enum {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // Byte-level predictor of the classifier plus the queue of verdicts still due
  class verdict_scoreboard;
    logic [15:0] match_port;
    logic [26:0] clone_count;
    logic [15:0] pos;
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [15:0] etype;
    logic [3:0]  hwords;
    logic [7:0]  proto;
    logic [31:0] daddr;
    logic [19:0] psum;
    logic [7:0]  hi_byte;
    logic [15:0] uport;
    logic        mflag;
    logic [31:0] mval;
    frame_verdict_t verdicts_due[$];
    int errors;

    function new();
      match_port  = MATCH_PORT_RESET;
      clone_count = CLONE_COUNT_RESET;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = '0; dmac = '0; smac = '0; etype = '0; hwords = '0; proto = '0;
      daddr = '0; psum = '0; hi_byte = '0; uport = '0; mflag = 1'b0; mval = '0;
    endfunction

    function void write_reg(logic idx, logic [26:0] val);
      if (idx == CFG_MATCH_PORT) match_port = val[15:0];
      else clone_count = val;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    // Advance the capture state by one transferred byte; queue a verdict on the last one
    function void take_byte(logic [7:0] b, logic lst, logic mp, logic [31:0] mc);
      int unsigned p;
      int unsigned udp_at;
      int unsigned len;
      int unsigned sum;
      logic [31:0] na;
      frame_verdict_t r;
      p = 32'(pos);
      if (p == 0) begin
        clear_frame();
        mflag = mp;
        mval  = mc;
      end
      if (p < 6) dmac = {dmac[39:0], b};
      else if (p < 12) smac = {smac[39:0], b};
      else if (p < 14) etype = {etype[7:0], b};
      if (p == 14) hwords = b[3:0];
      if (p == 23) proto = b;
      if (p >= 30 && p < 34) daddr = {daddr[23:0], b};
      // sum header words 0..7, skipping the checksum word
      if (p >= 14 && p < 30 && p != 24 && p != 25) begin
        if (((p - 14) & 1) == 0) hi_byte = b;
        else psum = psum + 20'({hi_byte, b});
      end
      udp_at = 14 + 4 * hwords;
      if (p == udp_at + 2) uport = {b, 8'h00};
      else if (p == udp_at + 3) uport = {uport[15:8], b};
      if (!lst) begin
        if (pos != 16'hFFFF) pos = pos + 16'd1;
        return;
      end
      pos = '0;
      len = p + 1;
      r.verdict = VERDICT_PASS; r.copies = '0; r.swapped = 1'b0; r.rewritten = 1'b0;
      r.dst_mac = dmac; r.src_mac = smac; r.dest_addr = daddr; r.ip_csum = '0;
      if (len >= 34 && etype == ETH_IPV4 && proto == PROTO_UDP && len >= udp_at + 8 &&
          uport == match_port) begin
        if (!mflag) begin
          r.verdict = VERDICT_CLONE;
          r.copies  = clone_count;
        end else if (mval == 32'd0) begin
          r.dst_mac = smac;
          r.src_mac = dmac;
          r.swapped = 1'b1;
        end else if (!mval[31]) begin
          na  = daddr + mval;
          sum = 32'(psum) + 32'(na[31:16]) + 32'(na[15:0]);
          while (sum >> 16) sum = (sum & 32'hFFFF) + (sum >> 16);
          r.ip_csum   = ~sum[15:0];
          r.dest_addr = na;
          r.rewritten = 1'b1;
          r.verdict   = VERDICT_BACK;
        end
      end
      verdicts_due.push_back(r);
    endfunction

    function void check_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    // Compare one transferred result with the oldest verdict due
    function void check_result(frame_verdict_t got);
      frame_verdict_t want;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, verdict %0d", $time, got.verdict);
        return;
      end
      want = verdicts_due.pop_front();
      check_field("verdict", 48'(want.verdict), 48'(got.verdict));
      check_field("copies", 48'(want.copies), 48'(got.copies));
      check_field("macs_swapped", 48'(want.swapped), 48'(got.swapped));
      check_field("header_rewritten", 48'(want.rewritten), 48'(got.rewritten));
      check_field("new_dst_mac", want.dst_mac, got.dst_mac);
      check_field("new_src_mac", want.src_mac, got.src_mac);
      check_field("new_dest_addr", 48'(want.dest_addr), 48'(got.dest_addr));
      check_field("new_ip_checksum", 48'(want.ip_csum), 48'(got.ip_csum));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic               cfg_index;
  logic [26:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               last_byte;
  logic               meta_present;
  logic signed [31:0] meta_count;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         verdict;
  logic [26:0]        copies;
  logic               macs_swapped;
  logic               header_rewritten;
  logic [47:0]        new_dst_mac;
  logic [47:0]        new_src_mac;
  logic [31:0]        new_dest_addr;
  logic [15:0]        new_ip_checksum;

  verdict_scoreboard sb;
  logic [7:0]  frame_q[$];
  logic [15:0] cur_port;
  int          burst_left;
  int          sent_bytes;
  bit          hold_req;

  udp_frame_clone_classifier_top dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_byte(last_byte),
    .meta_present(meta_present), .meta_count(meta_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .copies(copies), .macs_swapped(macs_swapped),
    .header_rewritten(header_rewritten), .new_dst_mac(new_dst_mac),
    .new_src_mac(new_src_mac), .new_dest_addr(new_dest_addr),
    .new_ip_checksum(new_ip_checksum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Check every result transfer
  always @(posedge clk) begin
    frame_verdict_t got;
    if (!rst && out_valid && out_ready) begin
      got.verdict   = verdict_t'(verdict);
      got.copies    = copies;
      got.swapped   = macs_swapped;
      got.rewritten = header_rewritten;
      got.dst_mac   = new_dst_mac;
      got.src_mac   = new_src_mac;
      got.dest_addr = new_dest_addr;
      got.ip_csum   = new_ip_checksum;
      sb.check_result(got);
    end
  end

  // Stall the result side on a changing pattern; hold off long when asked
  initial begin
    rx_mode_t mode;
    int left;
    int tick;
    out_ready = 1'b0;
    mode = RX_FREE;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (500) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      tick++;
      case (mode)
        RX_FREE:   out_ready = 1'b1;
        RX_RANDOM: out_ready = 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
        default:   out_ready = (tick % 5) < 3;
      endcase
    end
  end

  // Offer one byte in bursts with random gaps; return at a falling edge with valid low
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic mp,
                           input logic [31:0] mc);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    burst_left--;
    data_byte    = b;
    last_byte    = lst;
    meta_present = mp;
    meta_count   = mc;
    in_valid     = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_byte(b, lst, mp, mc);
    sent_bytes++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Metadata is sampled on the first byte only; scramble it on the rest
  task automatic send_frame(input logic mp, input logic [31:0] mc);
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) begin
      if (i == 0) send_byte(frame_q[i], n == 1, mp, mc);
      else send_byte(frame_q[i], i == n - 1, 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  task automatic write_cfg(input logic idx, input logic [26:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Wait until every verdict has come, then let the pipeline settle
  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void put(int at, logic [7:0] val);
    if (at < frame_q.size()) frame_q[at] = val;
  endfunction

  // Fill a frame with random bytes, then place the header fields that are in reach
  function automatic void make_frame(input logic [15:0] etype, input logic [7:0] proto,
                                     input logic [3:0] ihl, input logic [15:0] port,
                                     input logic [31:0] daddr, input int len);
    int udp_at;
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    udp_at = 14 + 4 * ihl;
    put(12, etype[15:8]);
    put(13, etype[7:0]);
    put(14, {4'($urandom_range(0, 15)), ihl});
    put(23, proto);
    put(30, daddr[31:24]);
    put(31, daddr[23:16]);
    put(32, daddr[15:8]);
    put(33, daddr[7:0]);
    put(udp_at + 2, port[15:8]);
    put(udp_at + 3, port[7:0]);
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 5))
      0, 5: return 32'd0;
      1: return $urandom_range(1, 1000);
      2: return $urandom;
      3: return {1'b0, 31'($urandom)};
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  // One random frame: mostly well-formed matches, then near misses and noise
  task automatic rand_frame();
    int kind;
    int r;
    int len;
    int min_len;
    logic [3:0]  ihl;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [15:0] port;
    r = $urandom_range(0, 9);
    if (r < 7) ihl = 4'd5;
    else if (r < 9) ihl = 4'($urandom_range(6, 15));
    else ihl = 4'($urandom_range(0, 4));
    min_len = 14 + 4 * ihl + 8;
    if (min_len < 34) min_len = 34;
    len   = min_len + $urandom_range(0, 12);
    etype = ETH_IPV4;
    proto = PROTO_UDP;
    port  = cur_port;
    kind  = $urandom_range(0, 9);
    case (kind)
      6: begin
        // near miss: one field off, or one byte short
        case ($urandom_range(0, 3))
          0: etype = etype ^ (16'd1 << $urandom_range(0, 15));
          1: proto = proto ^ (8'd1 << $urandom_range(0, 7));
          2: port  = port ^ (16'd1 << $urandom_range(0, 15));
          default: len = min_len - 1;
        endcase
      end
      7: begin
        etype = 16'($urandom);
        proto = 8'($urandom);
        port  = 16'($urandom);
        ihl   = 4'($urandom);
        len   = $urandom_range(1, 40);
      end
      8, 9: begin
        port = 16'($urandom);
        ihl  = 4'($urandom);
        len  = $urandom_range(1, 90);
        if (kind == 9) begin
          etype = 16'($urandom);
          proto = 8'($urandom);
        end
      end
      default: ;
    endcase
    make_frame(etype, proto, ihl, port, $urandom, len);
    send_frame(1'($urandom_range(0, 1)), pick_count());
  endtask

  task automatic run_phase(input logic [15:0] port, input logic [26:0] count,
                           input int min_bytes, input int min_frames);
    int start;
    int frames;
    wait_results();
    write_cfg(CFG_MATCH_PORT, {11'd0, port});
    write_cfg(CFG_CLONE_COUNT, count);
    cur_port = port;
    start  = sent_bytes;
    frames = 0;
    while (sent_bytes - start < min_bytes || frames < min_frames) begin
      rand_frame();
      frames++;
    end
  endtask

  // Directed frames under the reset configuration
  task automatic directed_frames();
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, $urandom, 42);
    send_frame(1'b0, 32'd0);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, $urandom, 42);
    send_frame(1'b1, 32'd0);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, 32'hFFFF_FFFF, 42);
    send_frame(1'b1, 32'd1);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, 32'h8000_0001, 50);
    send_frame(1'b1, 32'h7FFF_FFFF);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, $urandom, 42);
    send_frame(1'b1, 32'h8000_0000);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, $urandom, 42);
    send_frame(1'b1, 32'hFFFF_FFFF);
    // IP options outside the checksum
    make_frame(ETH_IPV4, PROTO_UDP, 4'd15, cur_port, $urandom, 82);
    send_frame(1'b1, 32'd77);
    // header length below five: port read from inside the IP header
    make_frame(ETH_IPV4, PROTO_UDP, 4'd3, cur_port, $urandom, 40);
    send_frame(1'b0, 32'd0);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd0, cur_port, $urandom, 34);
    send_frame(1'b1, 32'd0);
    // single-byte and short frames leave unreached fields at zero
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, $urandom, 1);
    send_frame(1'b1, 32'd3);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, $urandom, 33);
    send_frame(1'b0, 32'd0);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port, $urandom, 41);
    send_frame(1'b0, 32'd0);
    make_frame(16'h86DD, PROTO_UDP, 4'd5, cur_port, $urandom, 42);
    send_frame(1'b0, 32'd0);
    make_frame(ETH_IPV4, 8'd6, 4'd5, cur_port, $urandom, 42);
    send_frame(1'b0, 32'd0);
    make_frame(ETH_IPV4, PROTO_UDP, 4'd5, cur_port + 16'd1, $urandom, 42);
    send_frame(1'b0, 32'd0);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_MATCH_PORT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    last_byte    = 1'b0;
    meta_present = 1'b0;
    meta_count   = '0;
    hold_req     = 1'b0;
    burst_left   = 0;
    sent_bytes   = 0;
    cur_port     = MATCH_PORT_RESET;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_frames();
    run_phase(16'd0, 27'd0, 80, 2);
    run_phase(16'hFFFF, 27'h7FF_FFFF, 80, 2);
    run_phase(16'($urandom), 27'($urandom), 80, 2);

    // Hold off the receiver while short frames keep coming, so the block backs up
    wait_results();
    write_cfg(CFG_MATCH_PORT, 27'd53);
    write_cfg(CFG_CLONE_COUNT, 27'd1);
    cur_port = 16'd53;
    hold_req = 1'b1;
    repeat (40) begin
      make_frame(16'($urandom), 8'($urandom), 4'($urandom), 16'($urandom), $urandom,
                 $urandom_range(1, 4));
      send_frame(1'($urandom_range(0, 1)), pick_count());
    end
    repeat (2) rand_frame();

    run_phase(MATCH_PORT_RESET, 27'($urandom), 80, 2);

    wait_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+design
design/ufcc_pkg.sv
design/ufcc_parser.sv
design/ufcc_classify.sv
design/ufcc_csum.sv
design/udp_frame_clone_classifier_top.sv
verif/tb.sv
